// ===== rtl/core/cpl_pkg.sv =====
`timescale 1ns / 1ps

package cpl_pkg;

    // Width of one multiplier digit; each pipeline stage of a multiplier
    // handles one digit of its narrow operand.
    localparam int DIGIT_BITS = 8;

    // Number of digits, and so of pipeline stages, for an operand width.
    function automatic int digit_count(input int width);
        return (width + DIGIT_BITS - 1) / DIGIT_BITS;
    endfunction

endpackage

// ===== rtl/core/closest_points_between_lines_core.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     in_valid / in_ready       a_point_*, a_dir_*, b_point_*, b_dir_*
// output    out_valid / out_ready     near_a_*, near_b_*, lines_parallel
//
// One request enters per cycle while in_ready is high; latency is set by
// the pipeline depth of the chain of digit-serial multipliers (8 bits a
// stage) and the COORD_WIDTH+1 stage restoring divider.
// Reset clears only the valid bits of the pipeline.
// The whole pipeline holds while a result waits at the output unclaimed;
// nothing is dropped or repeated.

module closest_points_between_lines_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] a_point_x,
    input  logic signed [COORD_WIDTH-1:0] a_point_y,
    input  logic signed [COORD_WIDTH-1:0] a_point_z,
    input  logic signed [COORD_WIDTH-1:0] a_dir_x,
    input  logic signed [COORD_WIDTH-1:0] a_dir_y,
    input  logic signed [COORD_WIDTH-1:0] a_dir_z,
    input  logic signed [COORD_WIDTH-1:0] b_point_x,
    input  logic signed [COORD_WIDTH-1:0] b_point_y,
    input  logic signed [COORD_WIDTH-1:0] b_point_z,
    input  logic signed [COORD_WIDTH-1:0] b_dir_x,
    input  logic signed [COORD_WIDTH-1:0] b_dir_y,
    input  logic signed [COORD_WIDTH-1:0] b_dir_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] near_a_x,
    output logic signed [COORD_WIDTH-1:0] near_a_y,
    output logic signed [COORD_WIDTH-1:0] near_a_z,
    output logic signed [COORD_WIDTH-1:0] near_b_x,
    output logic signed [COORD_WIDTH-1:0] near_b_y,
    output logic signed [COORD_WIDTH-1:0] near_b_z,
    output logic                          lines_parallel
);

    localparam int CW  = COORD_WIDTH;
    localparam int NA  = cpl_pkg::digit_count(CW);
    localparam int ND  = cpl_pkg::digit_count(CW + 1);
    localparam int NM  = cpl_pkg::digit_count(2 * CW + 1);
    localparam int DW  = CW + 1;
    localparam int MW  = 2 * CW + 1;
    localparam int M2W = 4 * CW + 3;
    localparam int WW  = DW + MW + 1;
    localparam int NW  = WW + CW + 2;
    localparam int PW  = NW + CW;
    localparam int QB  = CW + 1;
    localparam int SW  = QB + 3;
    localparam int T1  = NA + 1;
    localparam int T2  = T1 + ND + 1;
    localparam int T3  = T2 + NA + 1;
    localparam int T4  = T3 + NA;
    localparam int T5  = T4 + QB + 2;
    localparam int LAT = T5 + 1;
    localparam int M2D = T4 - (T1 + NM + 1);

    logic                 en;
    logic [LAT-1:0]       vld_reg;
    logic signed [CW-1:0] p_in [3];
    logic signed [CW-1:0] u_in [3];
    logic signed [CW-1:0] q_in [3];
    logic signed [CW-1:0] v_in [3];
    logic signed [DW-1:0] d_in [3];
    wire  signed [DW-1:0] d_t1 [3];
    wire  signed [CW-1:0] u_t2 [3];
    wire  signed [CW-1:0] v_t2 [3];
    wire  signed [CW-1:0] u_t3 [3];
    wire  signed [CW-1:0] v_t3 [3];
    wire  signed [CW-1:0] pt_t5 [6];
    wire  signed [MW-1:0] m_w [3];
    wire  signed [WW-1:0] w_w [3];
    wire  signed [2*MW+1:0] m2_w;
    wire  [M2W-1:0]       m2_t4;
    wire  signed [NW-1:0] n1_w;
    wire  signed [NW-1:0] n2_w;
    wire  signed [PW-1:0] num_w [6];
    wire  signed [QB+1:0] quo_w [6];
    wire                  ovf_w [6];
    wire                  neg_w [6];
    logic                 par_t4;
    wire                  par_t5;
    logic signed [SW-1:0] max_v;
    logic signed [SW-1:0] min_v;
    logic signed [SW-1:0] sum [6];
    logic signed [CW-1:0] near_next [6];
    logic signed [CW-1:0] near_reg [6];
    logic                 par_reg;

    assign p_in[0] = a_point_x;
    assign p_in[1] = a_point_y;
    assign p_in[2] = a_point_z;
    assign u_in[0] = a_dir_x;
    assign u_in[1] = a_dir_y;
    assign u_in[2] = a_dir_z;
    assign q_in[0] = b_point_x;
    assign q_in[1] = b_point_y;
    assign q_in[2] = b_point_z;
    assign v_in[0] = b_dir_x;
    assign v_in[1] = b_dir_y;
    assign v_in[2] = b_dir_z;

    // Global pipeline enable: everything moves unless the output is held.
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // Offset between the line points, and aligned copies of the directions and the points.
    for (genvar k = 0; k < 3; k++)
    begin : g_vec
        assign d_in[k] = DW'(q_in[k]) - DW'(p_in[k]);

        cpl_delay #(.W(DW), .N(T1)) u_dly_d (
            .clk (clk), .en (en), .d (d_in[k]), .q (d_t1[k])
        );
        cpl_delay #(.W(CW), .N(T2)) u_dly_u2 (
            .clk (clk), .en (en), .d (u_in[k]), .q (u_t2[k])
        );
        cpl_delay #(.W(CW), .N(T2)) u_dly_v2 (
            .clk (clk), .en (en), .d (v_in[k]), .q (v_t2[k])
        );
        cpl_delay #(.W(CW), .N(NA + 1)) u_dly_u3 (
            .clk (clk), .en (en), .d (u_t2[k]), .q (u_t3[k])
        );
        cpl_delay #(.W(CW), .N(NA + 1)) u_dly_v3 (
            .clk (clk), .en (en), .d (v_t2[k]), .q (v_t3[k])
        );
        cpl_delay #(.W(CW), .N(LAT - 1)) u_dly_p (
            .clk (clk), .en (en), .d (p_in[k]), .q (pt_t5[k])
        );
        cpl_delay #(.W(CW), .N(LAT - 1)) u_dly_q (
            .clk (clk), .en (en), .d (q_in[k]), .q (pt_t5[k+3])
        );
    end

    // M = v x u.
    cpl_cross #(.WF(CW), .WS(CW)) u_cross_m (
        .clk (clk), .en (en), .f (v_in), .s (u_in), .r (m_w)
    );

    // m2 = |M|^2.
    cpl_dot #(.WA(MW), .WB(MW)) u_dot_m2 (
        .clk (clk), .en (en), .a (m_w), .b (m_w), .r (m2_w)
    );

    // W = D x M.
    cpl_cross #(.WF(DW), .WS(MW)) u_cross_w (
        .clk (clk), .en (en), .f (d_t1), .s (m_w), .r (w_w)
    );

    // Numerator scalars W.v and W.u.
    cpl_dot #(.WA(WW), .WB(CW)) u_dot_n1 (
        .clk (clk), .en (en), .a (w_w), .b (v_t2), .r (n1_w)
    );

    cpl_dot #(.WA(WW), .WB(CW)) u_dot_n2 (
        .clk (clk), .en (en), .a (w_w), .b (u_t2), .r (n2_w)
    );

    cpl_delay #(.W(M2W), .N(M2D)) u_dly_m2 (
        .clk (clk), .en (en), .d (m2_w[M2W-1:0]), .q (m2_t4)
    );

    assign par_t4 = (m2_t4 == '0);

    cpl_delay #(.W(1), .N(QB + 2)) u_dly_par (
        .clk (clk), .en (en), .d (par_t4), .q (par_t5)
    );

    // Six lanes: scale each direction component, then divide by m2.
    for (genvar j = 0; j < 6; j++)
    begin : g_lane
        if (j < 3)
        begin : g_first
            cpl_mul #(.WA(NW), .WB(CW)) u_mul (
                .clk (clk), .en (en), .a (n1_w), .b (u_t3[j]), .p (num_w[j])
            );
        end
        else
        begin : g_second
            cpl_mul #(.WA(NW), .WB(CW)) u_mul (
                .clk (clk), .en (en), .a (n2_w), .b (v_t3[j-3]), .p (num_w[j])
            );
        end

        cpl_div #(.NW(PW), .DW(M2W), .QB(QB)) u_div (
            .clk (clk),
            .en  (en),
            .num (num_w[j]),
            .den (m2_t4),
            .quo (quo_w[j]),
            .ovf (ovf_w[j]),
            .neg (neg_w[j])
        );
    end

    // Add the point, saturate, and pick the points unchanged when parallel.
    always_comb
    begin
        max_v = SW'({1'b0, {(CW-1){1'b1}}});
        min_v = -max_v - SW'(1);
        for (int j = 0; j < 6; j++)
        begin
            sum[j] = SW'(pt_t5[j]) + SW'(quo_w[j]);
            if (par_t5)
            begin
                near_next[j] = pt_t5[j];
            end
            else if (ovf_w[j])
            begin
                near_next[j] = neg_w[j] ? CW'(min_v) : CW'(max_v);
            end
            else if (sum[j] > max_v)
            begin
                near_next[j] = CW'(max_v);
            end
            else if (sum[j] < min_v)
            begin
                near_next[j] = CW'(min_v);
            end
            else
            begin
                near_next[j] = CW'(sum[j]);
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 6; j++)
            begin
                near_reg[j] <= near_next[j];
            end
            par_reg <= par_t5;
        end
    end

    assign out_valid      = vld_reg[LAT-1];
    assign near_a_x       = near_reg[0];
    assign near_a_y       = near_reg[1];
    assign near_a_z       = near_reg[2];
    assign near_b_x       = near_reg[3];
    assign near_b_y       = near_reg[4];
    assign near_b_z       = near_reg[5];
    assign lines_parallel = par_reg;

    // A held output must stop new requests.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while result is held");

    // A stall freezes every valid bit in flight.
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    // A result appears only from the stage before the output.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(vld_reg[LAT-2]))
        else $error("result appeared without a request behind it");

endmodule

// ===== rtl/core/cpl_delay.sv =====
`timescale 1ns / 1ps

module cpl_delay #(
    parameter int W = 32,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sh_reg [N];

    // Shift line that advances with the pipeline enable.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_reg[0] <= d;
            for (int k = 1; k < N; k++)
            begin
                sh_reg[k] <= sh_reg[k-1];
            end
        end
    end

    assign q = sh_reg[N-1];

endmodule

// ===== rtl/core/cpl_mul.sv =====
`timescale 1ns / 1ps

module cpl_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [WA-1:0] a,
    input  logic signed [WB-1:0] b,
    output logic signed [WA+WB-1:0] p
);

    localparam int DIG = cpl_pkg::DIGIT_BITS;
    localparam int ND  = cpl_pkg::digit_count(WB);
    localparam int BW  = ND * DIG;
    localparam int AW  = WA + BW + 1;

    logic signed [WA-1:0]  a_reg [ND];
    logic signed [WA-1:0]  a_next [ND];
    logic signed [BW-1:0]  b_reg [ND];
    logic signed [BW-1:0]  b_next [ND];
    logic signed [AW-1:0]  acc_reg [ND];
    logic signed [AW-1:0]  acc_next [ND];
    logic signed [BW-1:0]  b_ext;
    logic signed [WA-1:0]  a_src;
    logic signed [BW-1:0]  b_src;
    logic signed [AW-1:0]  acc_src;
    logic [DIG-1:0]        dig;
    logic signed [DIG:0]   dig_s;
    logic signed [WA+DIG:0] part;

    assign b_ext = BW'(b);

    // One digit of b per stage: the lower digits are unsigned, the top one
    // carries the sign.
    always_comb
    begin
        a_src   = a;
        b_src   = b_ext;
        acc_src = '0;
        dig     = '0;
        dig_s   = '0;
        part    = '0;
        for (int k = 0; k < ND; k++)
        begin
            if (k == 0)
            begin
                a_src   = a;
                b_src   = b_ext;
                acc_src = '0;
            end
            else
            begin
                a_src   = a_reg[k-1];
                b_src   = b_reg[k-1];
                acc_src = acc_reg[k-1];
            end
            dig = b_src[k*DIG +: DIG];
            if (k == ND - 1)
            begin
                dig_s = $signed({dig[DIG-1], dig});
            end
            else
            begin
                dig_s = $signed({1'b0, dig});
            end
            part        = a_src * dig_s;
            a_next[k]   = a_src;
            b_next[k]   = b_src;
            acc_next[k] = acc_src + (AW'(part) <<< (k * DIG));
        end
    end

    // Stage registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ND; k++)
            begin
                a_reg[k]   <= a_next[k];
                b_reg[k]   <= b_next[k];
                acc_reg[k] <= acc_next[k];
            end
        end
    end

    assign p = acc_reg[ND-1][WA+WB-1:0];

endmodule

// ===== rtl/core/cpl_cross.sv =====
`timescale 1ns / 1ps

module cpl_cross #(
    parameter int WF = 32,
    parameter int WS = 32
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [WF-1:0]    f [3],
    input  logic signed [WS-1:0]    s [3],
    output logic signed [WF+WS:0]   r [3]
);

    // Component c is f[c+1]*s[c+2] - f[c+2]*s[c+1], indices taken mod 3.
    for (genvar c = 0; c < 3; c++)
    begin : g_comp
        localparam int I1 = (c + 1) % 3;
        localparam int I2 = (c + 2) % 3;

        wire signed [WF+WS-1:0] pa;
        wire signed [WF+WS-1:0] pb;
        logic signed [WF+WS:0]  diff_reg;

        cpl_mul #(.WA(WS), .WB(WF)) u_mul_a (
            .clk (clk),
            .en  (en),
            .a   (s[I2]),
            .b   (f[I1]),
            .p   (pa)
        );

        cpl_mul #(.WA(WS), .WB(WF)) u_mul_b (
            .clk (clk),
            .en  (en),
            .a   (s[I1]),
            .b   (f[I2]),
            .p   (pb)
        );

        // Difference stage.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                diff_reg <= (WF+WS+1)'(pa) - (WF+WS+1)'(pb);
            end
        end

        assign r[c] = diff_reg;
    end

endmodule

// ===== rtl/core/cpl_dot.sv =====
`timescale 1ns / 1ps

module cpl_dot #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a [3],
    input  logic signed [WB-1:0]    b [3],
    output logic signed [WA+WB+1:0] r
);

    wire signed [WA+WB-1:0] prod [3];
    logic signed [WA+WB+1:0] sum_reg;

    for (genvar c = 0; c < 3; c++)
    begin : g_term
        cpl_mul #(.WA(WA), .WB(WB)) u_mul (
            .clk (clk),
            .en  (en),
            .a   (a[c]),
            .b   (b[c]),
            .p   (prod[c])
        );
    end

    // Three-term sum stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= (WA+WB+2)'(prod[0]) + (WA+WB+2)'(prod[1])
                     + (WA+WB+2)'(prod[2]);
        end
    end

    assign r = sum_reg;

endmodule

// ===== rtl/core/cpl_div.sv =====
`timescale 1ns / 1ps

module cpl_div #(
    parameter int NW = 165,
    parameter int DW = 131,
    parameter int QB = 33
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [NW-1:0]  num,
    input  logic [DW-1:0]         den,
    output logic signed [QB+1:0]  quo,
    output logic                  ovf,
    output logic                  neg
);

    logic [NW-1:0] r_reg [QB+1];
    logic [NW-1:0] r_next [QB+1];
    logic [DW-1:0] den_reg [QB+1];
    logic [DW-1:0] den_next [QB+1];
    logic [QB-1:0] q_reg [QB+1];
    logic [QB-1:0] q_next [QB+1];
    logic [QB:0]   neg_reg;
    logic [QB:0]   neg_next;
    logic [QB:0]   ovf_reg;
    logic [QB:0]   ovf_next;
    logic [NW-1:0] mag;
    logic [NW:0]   trial;
    logic          rnd;
    logic [QB:0]   mag_q;
    logic [QB+1:0] res;
    logic signed [QB+1:0] quo_reg;
    logic          ovf_out_reg;
    logic          neg_out_reg;

    // Entry stage takes the magnitude and flags a quotient that does not fit
    // in QB bits; then one restoring step per stage, MSB first.
    always_comb
    begin
        mag         = num[NW-1] ? NW'(-num) : NW'(num);
        r_next[0]   = mag;
        den_next[0] = den;
        q_next[0]   = '0;
        neg_next[0] = num[NW-1];
        ovf_next[0] = mag >= (NW'(den) << QB);
        trial       = '0;
        for (int s = 1; s <= QB; s++)
        begin
            den_next[s] = den_reg[s-1];
            neg_next[s] = neg_reg[s-1];
            ovf_next[s] = ovf_reg[s-1];
            trial = {1'b0, r_reg[s-1]} - ((NW+1)'(den_reg[s-1]) << (QB - s));
            if (!trial[NW])
            begin
                r_next[s] = trial[NW-1:0];
                q_next[s] = q_reg[s-1] | (QB'(1) << (QB - s));
            end
            else
            begin
                r_next[s] = r_reg[s-1];
                q_next[s] = q_reg[s-1];
            end
        end
    end

    // Round to nearest with ties away from zero, then restore the sign.
    always_comb
    begin
        rnd   = ({1'b0, r_reg[QB]} << 1) >= (NW+1)'(den_reg[QB]);
        mag_q = (QB+1)'(q_reg[QB]) + (QB+1)'(rnd);
        res   = neg_reg[QB] ? -((QB+2)'(mag_q)) : (QB+2)'(mag_q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s <= QB; s++)
            begin
                r_reg[s]   <= r_next[s];
                den_reg[s] <= den_next[s];
                q_reg[s]   <= q_next[s];
            end
            neg_reg     <= neg_next;
            ovf_reg     <= ovf_next;
            quo_reg     <= $signed(res);
            ovf_out_reg <= ovf_reg[QB];
            neg_out_reg <= neg_reg[QB];
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_out_reg;
    assign neg = neg_out_reg;

endmodule
